// File: sv/pqt_pkg.sv
package pqt_pkg;

  localparam int MaxResults = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ANSWER = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_SWEEP  = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_NONE_EXP  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] query_id;
    logic [31:0] hash_value;
    logic [47:0] context_data;
    logic [15:0] entity_length;
    logic        edns_enabled;
  } pqt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_query_id;
    logic [31:0] out_hash_value;
    logic [47:0] out_context_data;
    logic [15:0] out_entity_length;
    logic        out_edns_enabled;
    logic [6:0]  sweep_index;
    logic        last;
  } pqt_rsp_t;

endpackage

// File: sv/pending_query_table_with_timeout.sv
// Pending query table with timeout.
// A command is taken on start while busy is low; its fields come in as one
// struct on req. Results appear on rsp for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall them. Every command except tick and
// unused op codes gives at least one result, and the final one has last set.
// Insert, answer, find and delete scan the slots one per cycle through a
// single key comparator, then read the hit slot in a read state and register
// the result in an emit state; the result appears while busy is still high, in
// its last cycle. Sweep takes two steps on every slot, one reading it and one
// comparing its age against the timeout with one shared subtract-and-compare
// unit. An expired slot's result is held back until the next expired slot, or
// the end of the walk, shows whether it is the final one, so a sweep gives its
// final result in the last cycle that busy is high.
// Tick and the unused op codes keep busy high for one cycle. A new command can
// be taken as soon as busy is low. The stored entries sit in one memory
// that is written and read at a single address per cycle, with the read data
// registered. timeout_we writes the timeout register (reset value 2); write it
// only while busy is low. Reset clears the valid bits, the seconds counter and
// the sequencer; the memory is left as it is, since data of invalid slots is never used.
module pending_query_table_with_timeout #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pqt_pkg::pqt_req_t req,
  output logic              rsp_valid,
  output pqt_pkg::pqt_rsp_t rsp,
  input  logic              timeout_we,
  input  logic [7:0]        timeout_wdata
);
  import pqt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SWRD  = 3'd4;
  localparam logic [2:0] S_SWCHK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_SWEND = 3'd7;

  typedef struct packed {
    logic [47:0] key;
    logic [47:0] ctx;
    logic [16:0] lenflag;
    logic [31:0] stamp;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0] now;
  logic [7:0]  timeout;
  logic [2:0]  state;
  pqt_req_t    cur;
  logic [CW-1:0] idx;
  logic        hit;
  logic [IW-1:0] hit_slot;
  logic        free_found;
  logic [IW-1:0] free_slot;
  logic [6:0]  nexp;
  pqt_rsp_t    held;

  logic [47:0] cur_key;
  logic [IW-1:0] prev_slot;
  logic        key_eq;
  logic [31:0] age;
  logic        expired;

  assign cur_key   = {cur.query_id, cur.hash_value};
  assign prev_slot = IW'(idx - CW'(1));
  assign key_eq    = valid[prev_slot] && (rd.key == cur_key);
  assign age       = now - rd.stamp;
  assign expired   = valid[idx[IW-1:0]] && (age > {24'd0, timeout});
  assign busy      = (state != S_IDLE);

  function automatic pqt_rsp_t mk_rsp(input logic [2:0] st, input logic [47:0] k,
                                      input logic [47:0] c, input logic [16:0] lf,
                                      input logic [6:0] si, input logic lst);
    pqt_rsp_t r;
    r.status            = st;
    r.out_query_id      = k[47:32];
    r.out_hash_value    = k[31:0];
    r.out_context_data  = c;
    r.out_entity_length = lf[16:1];
    r.out_edns_enabled  = lf[0];
    r.sweep_index       = si;
    r.last              = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= 8'd2;
    end else if (timeout_we) begin
      timeout <= timeout_wdata;
    end
  end

  always_comb begin
    rd_addr = idx[IW-1:0];
    if (state == S_SCAN && (idx == CW'(TABLE_DEPTH) || (idx != '0 && hit))) begin
      rd_addr = hit_slot;
    end
    if (state == S_READ) begin
      rd_addr = hit_slot;
    end
  end

  // The scan pipeline: address idx is issued, data returns for idx-1.
  always_ff @(posedge clk) begin
    mem_we    <= 1'b0;
    rsp_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      now   <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= req;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            nexp       <= '0;
            if (req.op == OP_TICK) begin
              now   <= now + 32'd1;
              state <= S_DONE;
            end else if (req.op == OP_SWEEP) begin
              state <= S_SWRD;
            end else if (req.op <= OP_DELETE) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // rd holds slot idx-1 when idx is not zero.
          if (idx != '0 && !hit) begin
            if (key_eq) begin
              hit      <= 1'b1;
              hit_slot <= prev_slot;
            end
          end
          if (!free_found && !valid[idx[IW-1:0]] && idx != CW'(TABLE_DEPTH)) begin
            free_found <= 1'b1;
            free_slot  <= idx[IW-1:0];
          end
          if (idx == CW'(TABLE_DEPTH)) begin
            state <= S_READ;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          rsp_valid <= 1'b1;
          state     <= S_DONE;
          if (cur.op == OP_INSERT) begin
            if (hit) begin
              rsp <= mk_rsp(ST_DUPLICATE, rd.key, rd.ctx, rd.lenflag, 7'd0, 1'b1);
            end else if (!free_found) begin
              rsp <= mk_rsp(ST_FULL, '0, '0, '0, 7'd0, 1'b1);
            end else begin
              rsp <= mk_rsp(ST_OK, cur_key, cur.context_data,
                            {cur.entity_length, cur.edns_enabled}, 7'd0, 1'b1);
              valid[free_slot] <= 1'b1;
              mem_we  <= 1'b1;
              wr_addr <= free_slot;
              wr_data <= '{key: cur_key, ctx: cur.context_data,
                           lenflag: {cur.entity_length, cur.edns_enabled},
                           stamp: now};
            end
          end else if (!hit) begin
            rsp <= mk_rsp(ST_NOT_FOUND, '0, '0, '0, 7'd0, 1'b1);
          end else begin
            rsp <= mk_rsp(ST_OK, rd.key, rd.ctx,
                          (cur.op == OP_ANSWER) ? {cur.entity_length, cur.edns_enabled}
                                                : rd.lenflag, 7'd0, 1'b1);
            if (cur.op != OP_FIND) begin
              valid[hit_slot] <= 1'b0;
            end
          end
        end
        S_SWRD: begin
          state <= S_SWCHK;
        end
        S_SWCHK: begin
          // A held report goes out once another expired slot shows it is not final.
          if (expired && nexp < 7'(MaxResults)) begin
            if (nexp != '0) begin
              rsp_valid <= 1'b1;
              rsp       <= held;
            end
            held <= mk_rsp(ST_OK, rd.key, rd.ctx, rd.lenflag, nexp + 7'd1, 1'b0);
            valid[idx[IW-1:0]] <= 1'b0;
            nexp <= nexp + 7'd1;
          end
          if (idx == CW'(TABLE_DEPTH - 1)) begin
            state <= S_SWEND;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SWRD;
          end
        end
        S_SWEND: begin
          rsp_valid <= 1'b1;
          state     <= S_DONE;
          if (nexp == '0) begin
            rsp <= mk_rsp(ST_NONE_EXP, '0, '0, '0, 7'd0, 1'b1);
          end else begin
            rsp <= mk_rsp(held.status, {held.out_query_id, held.out_hash_value},
                          held.out_context_data,
                          {held.out_entity_length, held.out_edns_enabled},
                          held.sweep_index, 1'b1);
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("command not taken");
  a_rsp_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy) else $error("result outside a command");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= CW'(TABLE_DEPTH)) else $error("scan index out of range");

endmodule
